### rtl/csvt_pkg.sv
// shared types and constants of the csv record tokenizer
`timescale 1ns / 1ps

package csvt_pkg;

	// field widths
	localparam int BYTE_W = 8;
	localparam int EXP_W  = 9;
	localparam int POS_W  = 9;
	localparam int ROW_W  = 32;

	// default column limit of the field counter
	localparam int MAX_COLUMNS_DEF = 256;

	// special characters
	localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h22;
	localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
	localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;

	// error codes
	typedef enum logic [1:0] {
		ERR_NONE       = 2'd0,
		ERR_QUOTE_OPEN = 2'd1,
		ERR_QUOTE_BARE = 2'd2,
		ERR_COLUMNS    = 2'd3
	} csvt_err_t;

	// one result beat
	typedef struct packed {
		logic [BYTE_W-1:0] content_byte;
		logic              byte_valid;
		logic              field_end;
		logic              record_end;
		logic              stream_end;
		csvt_err_t         error_code;
		logic [POS_W-1:0]  field_position;
		logic [ROW_W-1:0]  row_index;
	} csvt_result_t;

endpackage

### rtl/csvt_ifs.sv
// valid/ready channels of the csv record tokenizer
`timescale 1ns / 1ps

interface csvt_byte_if import csvt_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_byte;
	logic              end_of_input;

	modport source (output valid, output data_byte, output end_of_input, input ready);
	modport sink (input valid, input data_byte, input end_of_input, output ready);
endinterface

interface csvt_token_if import csvt_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] content_byte;
	logic              byte_valid;
	logic              field_end;
	logic              record_end;
	logic              stream_end;
	logic [1:0]        error_code;
	logic [POS_W-1:0]  field_position;
	logic [ROW_W-1:0]  row_index;

	modport source (output valid, output content_byte, output byte_valid, output field_end,
		output record_end, output stream_end, output error_code, output field_position,
		output row_index, input ready);
	modport sink (input valid, input content_byte, input byte_valid, input field_end,
		input record_end, input stream_end, input error_code, input field_position,
		input row_index, output ready);
endinterface

interface csvt_cfg_if import csvt_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [EXP_W-1:0] expected_columns;

	modport source (output valid, output expected_columns, input ready);
	modport sink (input valid, input expected_columns, output ready);
endinterface

### rtl/csvt_core.sv
// scan state machine: one byte per step, at most one result per step
`timescale 1ns / 1ps

module csvt_core import csvt_pkg::*; #(
	parameter int MaxColumns = MAX_COLUMNS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [BYTE_W-1:0] data_byte,
	input  logic              end_of_input,
	input  logic [EXP_W-1:0]  expected_columns,
	output logic              res_fire,
	output csvt_result_t      res
);

	localparam int CntW = $clog2(MaxColumns + 1);
	localparam int CmpW = (CntW >= EXP_W) ? CntW + 1 : EXP_W + 1;
	localparam logic [CntW-1:0] CntMax = CntW'(MaxColumns);

	typedef enum logic [2:0] {
		MODE_UNQ,
		MODE_INQ,
		MODE_QSEEN,
		MODE_CRSEEN,
		MODE_DONE,
		MODE_ERR_OPEN,
		MODE_ERR_BARE,
		MODE_ERR_COLS
	} mode_t;

	mode_t            mode_q, mode_d;
	logic             has_content_q, has_content_d;
	logic             rec_started_q, rec_started_d;
	logic [CntW-1:0]  field_cnt_q, field_cnt_d;
	logic [ROW_W-1:0] row_q, row_d;

	logic             use_unq;
	logic             rec_close;
	logic             close_eoi;
	logic             close_cr;
	logic             raise;
	csvt_err_t        raise_code;
	logic             count_bad;
	logic [POS_W-1:0] pos_cur;

	assign pos_cur   = POS_W'(field_cnt_q);
	assign count_bad = (CmpW'(field_cnt_q) + CmpW'(1)) != CmpW'(expected_columns);

	// next state and result
	always_comb begin
		mode_d        = mode_q;
		has_content_d = has_content_q;
		rec_started_d = rec_started_q;
		field_cnt_d   = field_cnt_q;
		row_d         = row_q;
		res_fire      = 1'b0;
		res           = '0;
		res.row_index = row_q;
		use_unq       = 1'b0;
		rec_close     = 1'b0;
		close_eoi     = 1'b0;
		close_cr      = 1'b0;
		raise         = 1'b0;
		raise_code    = ERR_NONE;

		// modes with their own meaning for this byte
		if (step) begin
			unique case (mode_q)
				MODE_INQ: begin
					if (end_of_input) begin
						raise      = 1'b1;
						raise_code = ERR_QUOTE_OPEN;
					end else if (data_byte == CH_QUOTE) begin
						mode_d = MODE_QSEEN;
					end else begin
						has_content_d      = 1'b1;
						res_fire           = 1'b1;
						res.content_byte   = data_byte;
						res.byte_valid     = 1'b1;
						res.field_position = pos_cur;
					end
				end
				MODE_QSEEN: begin
					if (!end_of_input && data_byte == CH_QUOTE) begin
						mode_d             = MODE_INQ;
						has_content_d      = 1'b1;
						res_fire           = 1'b1;
						res.content_byte   = CH_QUOTE;
						res.byte_valid     = 1'b1;
						res.field_position = pos_cur;
					end else begin
						use_unq = 1'b1;
					end
				end
				MODE_CRSEEN: begin
					if (!end_of_input && data_byte == CH_LF) begin
						mode_d = MODE_UNQ;
					end else begin
						use_unq = 1'b1;
					end
				end
				MODE_DONE: begin
					if (end_of_input) begin
						res_fire       = 1'b1;
						res.stream_end = 1'b1;
					end
				end
				MODE_ERR_OPEN: begin
					res_fire           = 1'b1;
					res.error_code     = ERR_QUOTE_OPEN;
					res.field_position = pos_cur;
				end
				MODE_ERR_BARE: begin
					res_fire           = 1'b1;
					res.error_code     = ERR_QUOTE_BARE;
					res.field_position = pos_cur;
				end
				MODE_ERR_COLS: begin
					res_fire           = 1'b1;
					res.error_code     = ERR_COLUMNS;
					res.field_position = pos_cur;
				end
				default: begin
					use_unq = 1'b1;
				end
			endcase
		end

		// unquoted handling
		if (use_unq) begin
			mode_d = MODE_UNQ;
			if (end_of_input) begin
				if (rec_started_q) begin
					rec_close = 1'b1;
					close_eoi = 1'b1;
				end else if (row_q == ROW_W'(1)) begin
					raise      = 1'b1;
					raise_code = ERR_COLUMNS;
				end else begin
					mode_d         = MODE_DONE;
					res_fire       = 1'b1;
					res.stream_end = 1'b1;
				end
			end else begin
				rec_started_d = 1'b1;
				priority if (data_byte == CH_QUOTE) begin
					if (has_content_q) begin
						raise      = 1'b1;
						raise_code = ERR_QUOTE_BARE;
					end else begin
						mode_d = MODE_INQ;
					end
				end else if (data_byte == CH_COMMA) begin
					res_fire           = 1'b1;
					res.field_end      = 1'b1;
					res.field_position = pos_cur;
					if (field_cnt_q < CntMax) begin
						field_cnt_d = field_cnt_q + CntW'(1);
					end
					has_content_d = 1'b0;
				end else if (data_byte == CH_LF) begin
					rec_close = 1'b1;
				end else if (data_byte == CH_CR) begin
					rec_close = 1'b1;
					close_cr  = 1'b1;
				end else begin
					has_content_d      = 1'b1;
					res_fire           = 1'b1;
					res.content_byte   = data_byte;
					res.byte_valid     = 1'b1;
					res.field_position = pos_cur;
				end
			end
		end

		// record close with column check
		if (rec_close) begin
			if (count_bad) begin
				raise      = 1'b1;
				raise_code = ERR_COLUMNS;
			end else begin
				res_fire           = 1'b1;
				res.field_end      = 1'b1;
				res.record_end     = 1'b1;
				res.stream_end     = close_eoi;
				res.field_position = pos_cur;
				field_cnt_d        = '0;
				has_content_d      = 1'b0;
				rec_started_d      = 1'b0;
				if (row_q != '1) begin
					row_d = row_q + ROW_W'(1);
				end
				if (close_eoi) begin
					mode_d = MODE_DONE;
				end else if (close_cr) begin
					mode_d = MODE_CRSEEN;
				end
			end
		end

		// sticky error entry
		if (raise) begin
			res_fire           = 1'b1;
			res.error_code     = raise_code;
			res.field_position = pos_cur;
			unique case (raise_code)
				ERR_QUOTE_OPEN: mode_d = MODE_ERR_OPEN;
				ERR_QUOTE_BARE: mode_d = MODE_ERR_BARE;
				default:        mode_d = MODE_ERR_COLS;
			endcase
		end
	end

	// scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= MODE_UNQ;
			has_content_q <= 1'b0;
			rec_started_q <= 1'b0;
			field_cnt_q   <= '0;
			row_q         <= ROW_W'(1);
		end else begin
			mode_q        <= mode_d;
			has_content_q <= has_content_d;
			rec_started_q <= rec_started_d;
			field_cnt_q   <= field_cnt_d;
			row_q         <= row_d;
		end
	end

endmodule

### rtl/csv_record_tokenizer.sv
// top level of the csv record tokenizer: input register, scanner, result register
// path: a byte beat is held in the input register, scanned, and its result beat is offered from the result register
// throughput: one byte beat per cycle unless the result register stalls the input
// a full result register stalls the input only while the result is not taken
// reset: asynchronous, clears the scan state, row number to 1, expected_columns to 1
`timescale 1ns / 1ps

module csv_record_tokenizer import csvt_pkg::*; #(
	parameter int MaxColumns = MAX_COLUMNS_DEF
) (
	input logic          clk,
	input logic          arst_n,
	csvt_cfg_if.sink     cfg,
	csvt_byte_if.sink    bytes,
	csvt_token_if.source tokens
);

	logic [EXP_W-1:0]  exp_cols_q;
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              eoi_s1;
	logic              advance;
	logic              res_fire;
	csvt_result_t      res;
	logic              out_valid_q;
	csvt_result_t      out_q;

	// configuration register
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_cols_q <= EXP_W'(1);
		end else if (cfg.valid) begin
			exp_cols_q <= cfg.expected_columns;
		end
	end

	// input register
	assign advance     = valid_s1 && (!out_valid_q || tokens.ready);
	assign bytes.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes.valid && bytes.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.valid && bytes.ready) begin
			byte_s1 <= bytes.data_byte;
			eoi_s1  <= bytes.end_of_input;
		end
	end

	csvt_core #(
		.MaxColumns(MaxColumns)
	) u_core (
		.clk              (clk),
		.arst_n           (arst_n),
		.step             (advance),
		.data_byte        (byte_s1),
		.end_of_input     (eoi_s1),
		.expected_columns (exp_cols_q),
		.res_fire         (res_fire),
		.res              (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res_fire) begin
			out_valid_q <= 1'b1;
		end else if (tokens.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_fire) begin
			out_q <= res;
		end
	end

	assign tokens.valid          = out_valid_q;
	assign tokens.content_byte   = out_q.content_byte;
	assign tokens.byte_valid     = out_q.byte_valid;
	assign tokens.field_end      = out_q.field_end;
	assign tokens.record_end     = out_q.record_end;
	assign tokens.stream_end     = out_q.stream_end;
	assign tokens.error_code     = out_q.error_code;
	assign tokens.field_position = out_q.field_position;
	assign tokens.row_index      = out_q.row_index;

endmodule
